FILE: rtl/core/loe_pkg.sv
package loe_pkg;

	localparam int MAX_BOXES = 1024;
	localparam int IDX_W     = 11;
	localparam int SUM_W     = 19;
	localparam int ACT_W     = 3;
	localparam int UPC_W     = 5;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_BOXES);

	localparam logic [ACT_W-1:0] ACT_INIT   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_LEFT   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RIGHT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SWAP   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_REV    = 3'd4;
	localparam logic [ACT_W-1:0] ACT_REPORT = 3'd5;

	localparam logic [2:0] C_NEVER = 3'd0;
	localparam logic [2:0] C_MORE  = 3'd1;
	localparam logic [2:0] C_SKIP  = 3'd2;
	localparam logic [2:0] C_LEFT  = 3'd3;
	localparam logic [2:0] C_RIGHT = 3'd4;
	localparam logic [2:0] C_NYX   = 3'd5;
	localparam logic [2:0] C_NXY   = 3'd6;

	localparam logic [1:0] RS_X    = 2'd0;
	localparam logic [1:0] RS_Y    = 2'd1;
	localparam logic [1:0] RS_ZERO = 2'd2;
	localparam logic [1:0] RS_WALK = 2'd3;

	localparam logic [3:0] SA_ZERO = 4'd0;
	localparam logic [3:0] SA_X    = 4'd1;
	localparam logic [3:0] SA_Y    = 4'd2;
	localparam logic [3:0] SA_NX   = 4'd3;
	localparam logic [3:0] SA_PX   = 4'd4;
	localparam logic [3:0] SA_NY   = 4'd5;
	localparam logic [3:0] SA_PY   = 4'd6;
	localparam logic [3:0] SA_CNT  = 4'd7;
	localparam logic [3:0] SA_CNT1 = 4'd8;

	localparam logic [UPC_W-1:0] U_MOVE  = 5'd0;
	localparam logic [UPC_W-1:0] U_LEFT  = 5'd12;
	localparam logic [UPC_W-1:0] U_RIGHT = 5'd15;
	localparam logic [UPC_W-1:0] U_SWA   = 5'd18;
	localparam logic [UPC_W-1:0] U_SWB   = 5'd21;
	localparam logic [UPC_W-1:0] U_NOP   = 5'd24;
	localparam logic [UPC_W-1:0] U_INIT  = 5'd25;
	localparam logic [UPC_W-1:0] U_INITL = 5'd26;
	localparam logic [UPC_W-1:0] U_REV   = 5'd28;
	localparam logic [UPC_W-1:0] U_REP   = 5'd29;
	localparam logic [UPC_W-1:0] U_REPL  = 5'd30;

	typedef struct packed {
		logic             end_step;
		logic             emit;
		logic             wr;
		logic [3:0]       src_a;
		logic [3:0]       src_b;
		logic [1:0]       rsel;
		logic             latch_x;
		logic             latch_y;
		logic             cnt_clr;
		logic             cnt_inc;
		logic             sum_clr;
		logic             sum_acc;
		logic             init_set;
		logic             rev_tog;
		logic [2:0]       cond;
		logic [UPC_W-1:0] target;
	} ucw_t;

	typedef struct packed {
		logic fire;
		ucw_t ucw;
	} seq_out_t;

	typedef struct packed {
		logic             go;
		logic [UPC_W-1:0] entry;
		logic             skip;
		logic             left;
		logic             right;
		logic             ny_x;
		logic             nx_y;
		logic             more;
		logic             out_block;
	} loe_stat_t;

	function automatic logic [IDX_W-1:0] clip_idx(input logic [IDX_W-1:0] v);
		return (v <= IDX_MAX) ? v : '0;
	endfunction

	function automatic ucw_t join_w(input logic [3:0] a, input logic [3:0] b, input logic last);
		ucw_t w;
		w          = '0;
		w.wr       = 1'b1;
		w.src_a    = a;
		w.src_b    = b;
		w.end_step = last;
		return w;
	endfunction

	function automatic ucw_t jump_w(input logic [2:0] c, input logic [UPC_W-1:0] t);
		ucw_t w;
		w        = '0;
		w.cond   = c;
		w.target = t;
		return w;
	endfunction

	function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
		ucw_t w;
		w = '0;
		case (upc)
			5'd0: begin
				w.rsel = RS_X;
			end
			5'd1: begin
				w.rsel    = RS_Y;
				w.latch_x = 1'b1;
			end
			5'd2: begin
				w.latch_y = 1'b1;
			end
			5'd3:  w = jump_w(C_SKIP, U_NOP);
			5'd4:  w = jump_w(C_LEFT, U_LEFT);
			5'd5:  w = jump_w(C_RIGHT, U_RIGHT);
			5'd6:  w = jump_w(C_NYX, U_SWA);
			5'd7:  w = jump_w(C_NXY, U_SWB);
			5'd8:  w = join_w(SA_PX, SA_Y, 1'b0);
			5'd9:  w = join_w(SA_Y, SA_NX, 1'b0);
			5'd10: w = join_w(SA_PY, SA_X, 1'b0);
			5'd11: w = join_w(SA_X, SA_NY, 1'b1);
			5'd12: w = join_w(SA_PY, SA_X, 1'b0);
			5'd13: w = join_w(SA_X, SA_Y, 1'b0);
			5'd14: w = join_w(SA_PX, SA_NX, 1'b1);
			5'd15: w = join_w(SA_Y, SA_X, 1'b0);
			5'd16: w = join_w(SA_X, SA_NY, 1'b0);
			5'd17: w = join_w(SA_PX, SA_NX, 1'b1);
			5'd18: w = join_w(SA_PY, SA_X, 1'b0);
			5'd19: w = join_w(SA_X, SA_Y, 1'b0);
			5'd20: w = join_w(SA_Y, SA_NX, 1'b1);
			5'd21: w = join_w(SA_PX, SA_Y, 1'b0);
			5'd22: w = join_w(SA_Y, SA_X, 1'b0);
			5'd23: w = join_w(SA_X, SA_NY, 1'b1);
			5'd24: begin
				w.end_step = 1'b1;
			end
			5'd25: begin
				w.cnt_clr  = 1'b1;
				w.init_set = 1'b1;
			end
			5'd26: begin
				w         = join_w(SA_CNT, SA_CNT1, 1'b0);
				w.cnt_inc = 1'b1;
				w.cond    = C_MORE;
				w.target  = U_INITL;
			end
			5'd27: w = join_w(SA_CNT, SA_ZERO, 1'b1);
			5'd28: begin
				w.rev_tog  = 1'b1;
				w.end_step = 1'b1;
			end
			5'd29: begin
				w.rsel    = RS_ZERO;
				w.cnt_clr = 1'b1;
				w.sum_clr = 1'b1;
			end
			5'd30: begin
				w.rsel    = RS_WALK;
				w.sum_acc = 1'b1;
				w.cnt_inc = 1'b1;
				w.cond    = C_MORE;
				w.target  = U_REPL;
			end
			5'd31: begin
				w.emit     = 1'b1;
				w.end_step = 1'b1;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/loe_ram.sv
module loe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/loe_useq.sv
module loe_useq
	import loe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_acc,
	input  loe_stat_t stat,
	output logic      idle,
	output seq_out_t  sq
);

	logic             busy_q;
	logic [UPC_W-1:0] upc_q;
	ucw_t             ucw;
	logic             fire;
	logic             take;

	assign ucw  = ucode(upc_q);
	assign fire = busy_q && !(ucw.emit && stat.out_block);
	assign idle = !busy_q;

	always_comb begin
		case (ucw.cond)
			C_MORE:  take = stat.more;
			C_SKIP:  take = stat.skip;
			C_LEFT:  take = stat.left;
			C_RIGHT: take = stat.right;
			C_NYX:   take = stat.ny_x;
			C_NXY:   take = stat.nx_y;
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= '0;
		end else if (!busy_q) begin
			if (in_acc && stat.go) begin
				busy_q <= 1'b1;
				upc_q  <= stat.entry;
			end
		end else if (fire) begin
			if (ucw.end_step) begin
				busy_q <= 1'b0;
			end else if (take) begin
				upc_q <= ucw.target;
			end else begin
				upc_q <= upc_q + 1'b1;
			end
		end
	end

	assign sq.fire = fire;
	assign sq.ucw  = ucw;

`ifndef SYNTH
	a_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(fire && ucw.end_step))
		else $error("sequencer left a program without an end step");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !fire) |=> (upc_q == $past(upc_q)) && busy_q)
		else $error("step counter moved during an output stall");

	a_fallthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !ucw.end_step && ucw.cond == C_NEVER) |=> upc_q == $past(upc_q) + 1'b1)
		else $error("step counter skipped a step");
`endif

endmodule

FILE: rtl/core/loe_dpath.sv
module loe_dpath
	import loe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_wr_data,
	input  logic             in_acc,
	input  logic [ACT_W-1:0] in_action,
	input  logic [IDX_W-1:0] in_x,
	input  logic [IDX_W-1:0] in_y,
	input  seq_out_t         sq,
	output loe_stat_t        stat,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SUM_W-1:0] out_sum
);

	localparam int DEPTH = MAX_BOXES + 1;

	logic [IDX_W-1:0] box_count_q;
	logic [IDX_W-1:0] built_q;
	logic             rev_q;
	logic [ACT_W-1:0] act_q;
	logic [IDX_W-1:0] x_q, y_q, nx_q, px_q, ny_q, py_q;
	logic [IDX_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;

	logic [IDX_W-1:0] eff_n;
	logic             ok;
	logic [ACT_W-1:0] act_eff;
	logic             st_go;
	logic [UPC_W-1:0] st_entry;
	logic [IDX_W-1:0] next_rd, prev_rd, raddr, walk_pos;
	logic [IDX_W-1:0] ja, jb;
	logic [SUM_W:0]   sum_add;
	ucw_t             w;

	assign w = sq.ucw;

	always_comb begin
		if (box_count_q == '0) begin
			eff_n = IDX_W'(1);
		end else if (box_count_q > IDX_MAX) begin
			eff_n = IDX_MAX;
		end else begin
			eff_n = box_count_q;
		end
	end

	assign ok = (in_x != '0) && (in_y != '0) && (in_x <= built_q) && (in_y <= built_q)
		&& (in_x != in_y);

	always_comb begin
		act_eff = in_action;
		if (rev_q && in_action == ACT_LEFT) begin
			act_eff = ACT_RIGHT;
		end else if (rev_q && in_action == ACT_RIGHT) begin
			act_eff = ACT_LEFT;
		end
	end

	always_comb begin
		st_go    = 1'b0;
		st_entry = U_NOP;
		case (in_action)
			ACT_INIT: begin
				st_go    = 1'b1;
				st_entry = U_INIT;
			end
			ACT_LEFT, ACT_RIGHT, ACT_SWAP: begin
				st_go    = ok;
				st_entry = U_MOVE;
			end
			ACT_REV: begin
				st_go    = 1'b1;
				st_entry = U_REV;
			end
			ACT_REPORT: begin
				st_go    = 1'b1;
				st_entry = U_REP;
			end
			default: st_go = 1'b0;
		endcase
	end

	assign stat.go    = st_go;
	assign stat.entry = st_entry;
	assign stat.skip  = (act_q == ACT_LEFT && py_q == x_q) || (act_q == ACT_RIGHT && ny_q == x_q);
	assign stat.left  = act_q == ACT_LEFT;
	assign stat.right = act_q == ACT_RIGHT;
	assign stat.ny_x  = ny_q == x_q;
	assign stat.nx_y  = nx_q == y_q;
	assign stat.more  = ({1'b0, cnt_q} + 1'b1) < {1'b0, eff_n};
	assign stat.out_block = out_valid_q && !out_ready;

	assign walk_pos = clip_idx(rev_q ? prev_rd : next_rd);

	always_comb begin
		case (w.rsel)
			RS_X:    raddr = x_q;
			RS_Y:    raddr = y_q;
			RS_WALK: raddr = walk_pos;
			default: raddr = '0;
		endcase
	end

	function automatic logic [IDX_W-1:0] pick(
		input logic [3:0]       s,
		input logic [IDX_W-1:0] x, y, nx, px, ny, py, cnt
	);
		case (s)
			SA_X:    return x;
			SA_Y:    return y;
			SA_NX:   return nx;
			SA_PX:   return px;
			SA_NY:   return ny;
			SA_PY:   return py;
			SA_CNT:  return cnt;
			SA_CNT1: return cnt + 1'b1;
			default: return '0;
		endcase
	endfunction

	assign ja = clip_idx(pick(w.src_a, x_q, y_q, nx_q, px_q, ny_q, py_q, cnt_q));
	assign jb = clip_idx(pick(w.src_b, x_q, y_q, nx_q, px_q, ny_q, py_q, cnt_q));

	loe_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_next (
		.clk   (clk),
		.we    (sq.fire && w.wr),
		.waddr (ja),
		.wdata (jb),
		.raddr (raddr),
		.rdata (next_rd)
	);

	loe_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_prev (
		.clk   (clk),
		.we    (sq.fire && w.wr),
		.waddr (jb),
		.wdata (ja),
		.raddr (raddr),
		.rdata (prev_rd)
	);

	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(walk_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q <= IDX_W'(1);
			built_q     <= '0;
			rev_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				box_count_q <= cfg_wr_data;
			end
			if (sq.fire && w.init_set) begin
				built_q <= eff_n;
				rev_q   <= 1'b0;
			end else if (sq.fire && w.rev_tog) begin
				rev_q <= !rev_q;
			end
			if (sq.fire && w.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= act_eff;
			x_q   <= in_x;
			y_q   <= in_y;
		end
		if (sq.fire) begin
			if (w.latch_x) begin
				nx_q <= next_rd;
				px_q <= prev_rd;
			end
			if (w.latch_y) begin
				ny_q <= next_rd;
				py_q <= prev_rd;
			end
			if (w.cnt_clr) begin
				cnt_q <= '0;
			end else if (w.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (w.sum_clr) begin
				sum_q <= '0;
			end else if (w.sum_acc && !cnt_q[0]) begin
				sum_q <= (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
			end
			if (w.emit) begin
				out_sum_q <= sum_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;

endmodule

FILE: rtl/core/line_order_list_engine.sv
// Box line engine: keeps boxes 1..n in a circular doubly linked list held in two
// link memories, with a reversed flag, and runs one request at a time.
// Requests enter on the s_axis group and carry an action with two box labels.
// Only a report request produces an output, the sum of the labels at odd
// positions, which leaves on the m_axis group.
// The box count register is written through cfg_wr_en and cfg_wr_data; the user
// must do so only while idle, which the block itself does not enforce.
// Each request that is not ignored runs as a short program from a microcode
// table, one step a cycle unless a report's final step waits on the output
// register; a move already in place writes no link, and ignored requests never
// start a program. Init and report step through the line one link at a time,
// through the single write and read port of each link memory; a report's sum
// is valid in the output register from the cycle after its last step.
// s_tready is high whenever no program is running, so a request is taken while
// a report result still waits in the output register.
// If the receiver stalls, a later report halts on its final step until the
// output register is free; nothing is dropped.
// Reset clears the flag, the box count to one, and marks no line as built; the
// link memories are not cleared, and init must precede moves and reports.
module line_order_list_engine
	import loe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,   // box_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // action[2:0], box_x[13:3], box_y[24:14]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // odd_position_sum[18:0]
);

	logic             idle;
	logic             in_acc;
	seq_out_t         sq;
	loe_stat_t        stat;
	logic [SUM_W-1:0] out_sum;

	assign s_axis_tready = idle;
	assign in_acc        = s_axis_tvalid && idle;

	loe_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.in_acc (in_acc),
		.stat   (stat),
		.idle   (idle),
		.sq     (sq)
	);

	loe_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_acc      (in_acc),
		.in_action   (s_axis_tdata[2:0]),
		.in_x        (s_axis_tdata[13:3]),
		.in_y        (s_axis_tdata[24:14]),
		.sq          (sq),
		.stat        (stat),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_sum     (out_sum)
	);

	assign m_axis_tdata = {5'd0, out_sum};

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb
	import loe_pkg::*;
();

	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;
	localparam int unsigned SUM_CAP = 524287;
	localparam int LONG_HOLD = 400;
	localparam int TAIL_CYCLES = 1100;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [IDX_W-1:0] bx;
		logic [IDX_W-1:0] by;
	} box_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [10:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	line_order_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the line: link memories, direction flag and box count register.
	logic [IDX_W-1:0] lk_next [0:MAX_BOXES];
	logic [IDX_W-1:0] lk_prev [0:MAX_BOXES];
	bit lk_rev = 1'b0;
	int unsigned lk_built = 0;
	logic [10:0] reg_box_count = 11'd1;
	logic [SUM_W-1:0] sums_due[$];

	box_req_t pend_q[$];
	box_req_t cur_req;
	int unsigned plan_built = 0;
	bit hold_req = 1'b0;
	int errs = 0;
	int reqs_taken = 0;
	int sums_checked = 0;
	int counts_written = 0;

	function automatic int unsigned box_eff(input logic [10:0] v);
		if (v < 1) return 1;
		if (v > MAX_BOXES) return MAX_BOXES;
		return v;
	endfunction

	function automatic void link(input int unsigned a, input int unsigned b);
		lk_next[a] = IDX_W'(b);
		lk_prev[b] = IDX_W'(a);
	endfunction

	function automatic void line_apply(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] x,
			input logic [IDX_W-1:0] y);
		int unsigned n;
		int unsigned pos;
		int unsigned acc;
		logic [ACT_W-1:0] op;
		int unsigned nx, px, ny, py;
		bit ok;
		ok = x >= 1 && y >= 1 && x <= lk_built && y <= lk_built && x != y;
		case (act)
			ACT_INIT: begin
				n = box_eff(reg_box_count);
				for (int i = 0; i < n; i++)
					link(i, i + 1);
				link(n, 0);
				lk_built = n;
				lk_rev = 1'b0;
			end
			ACT_REV: begin
				lk_rev = !lk_rev;
			end
			ACT_REPORT: begin
				n = box_eff(reg_box_count);
				pos = 0;
				acc = 0;
				for (int i = 0; i < n; i++) begin
					pos = lk_rev ? lk_prev[pos] : lk_next[pos];
					if (i % 2 == 0) begin
						acc += pos;
						if (acc > SUM_CAP)
							acc = SUM_CAP;
					end
				end
				sums_due.push_back(acc[SUM_W-1:0]);
			end
			ACT_LEFT, ACT_RIGHT, ACT_SWAP: begin
				if (ok) begin
					op = act;
					if (lk_rev && act == ACT_LEFT)
						op = ACT_RIGHT;
					else if (lk_rev && act == ACT_RIGHT)
						op = ACT_LEFT;
					nx = lk_next[x];
					px = lk_prev[x];
					ny = lk_next[y];
					py = lk_prev[y];
					if (op == ACT_LEFT) begin
						if (py != x) begin
							link(py, x);
							link(x, y);
							link(px, nx);
						end
					end else if (op == ACT_RIGHT) begin
						if (ny != x) begin
							link(y, x);
							link(x, ny);
							link(px, nx);
						end
					end else if (ny == x) begin
						link(py, x);
						link(x, y);
						link(y, nx);
					end else if (nx == y) begin
						link(px, y);
						link(y, x);
						link(x, ny);
					end else begin
						link(px, y);
						link(y, nx);
						link(py, x);
						link(x, ny);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [31:0] pack_req(input box_req_t r);
		return {7'd0, r.by, r.bx, r.act};
	endfunction

	// Request driver.
	int tx_wait = 0;
	int tx_gap;
	bit tx_calm = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				line_apply(cur_req.act, cur_req.bx, cur_req.by);
				reqs_taken++;
				tx_gap = tx_calm ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 39) == 0)
					tx_calm = !tx_calm;
				if (tx_gap == 0 && pend_q.size() != 0) begin
					cur_req = pend_q.pop_front();
					s_axis_tdata <= pack_req(cur_req);
				end else begin
					s_axis_tvalid <= 1'b0;
					tx_wait <= (tx_gap > 0) ? tx_gap - 1 : 0;
				end
			end else if (!s_axis_tvalid) begin
				if (tx_wait > 0) begin
					tx_wait <= tx_wait - 1;
				end else if (pend_q.size() != 0) begin
					cur_req = pend_q.pop_front();
					s_axis_tdata <= pack_req(cur_req);
					s_axis_tvalid <= 1'b1;
				end
			end
		end
	end

	// Result monitor and receiver stalls.
	int rx_wait = 0;
	int rx_hold = 0;
	int rx_gap;
	bit rx_calm = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (sums_due.size() == 0) begin
					$error("odd_position_sum: no result expected, got %0d", m_axis_tdata[SUM_W-1:0]);
					errs++;
				end else begin
					if (m_axis_tdata[SUM_W-1:0] !== sums_due[0]) begin
						$error("odd_position_sum: expected %0d, got %0d", sums_due[0],
							m_axis_tdata[SUM_W-1:0]);
						errs++;
					end
					void'(sums_due.pop_front());
					sums_checked++;
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				rx_hold <= LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (rx_hold != 0) begin
				rx_hold <= rx_hold - 1;
				m_axis_tready <= (rx_hold == 1);
			end else if (m_axis_tvalid && m_axis_tready) begin
				rx_gap = rx_calm ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 29) == 0)
					rx_calm = !rx_calm;
				rx_wait <= rx_gap;
				m_axis_tready <= (rx_gap == 0);
			end else if (!m_axis_tready) begin
				if (rx_wait > 1) begin
					rx_wait <= rx_wait - 1;
				end else begin
					rx_wait <= 0;
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	longint cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [IDX_W-1:0] rnd_box();
		return IDX_W'($urandom_range(0, 2047));
	endfunction

	function automatic logic [ACT_W-1:0] pick_move();
		case ($urandom_range(0, 2))
			0: return ACT_LEFT;
			1: return ACT_RIGHT;
			default: return ACT_SWAP;
		endcase
	endfunction

	task automatic push_req(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] x,
			input logic [IDX_W-1:0] y);
		box_req_t r;
		r.act = act;
		r.bx = x;
		r.by = y;
		if (act == ACT_INIT)
			plan_built = box_eff(reg_box_count);
		pend_q.push_back(r);
	endtask

	task automatic wait_idle(input int settle);
		while (pend_q.size() != 0 || s_axis_tvalid || sums_due.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic set_box_count(input logic [10:0] v);
		wait_idle(box_eff(reg_box_count) + 16);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		reg_box_count = v;
		counts_written++;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [10:0] cnt, input int n_items, input bit with_init,
			input int rep_pct, input bit long_hold);
		int r;
		logic [IDX_W-1:0] x;
		logic [IDX_W-1:0] y;
		set_box_count(cnt);
		if (long_hold)
			hold_req = 1'b1;
		if (with_init)
			push_req(ACT_INIT, rnd_box(), rnd_box());
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < rep_pct) begin
				push_req(ACT_REPORT, rnd_box(), rnd_box());
			end else if (r < rep_pct + 6) begin
				push_req(ACT_REV, rnd_box(), rnd_box());
			end else if (r < rep_pct + 8 && with_init) begin
				push_req(ACT_INIT, rnd_box(), rnd_box());
			end else if (r < rep_pct + 10) begin
				push_req($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B, rnd_box(), rnd_box());
			end else if (r < rep_pct + 13) begin
				push_req(pick_move(), rnd_box(), rnd_box());
			end else begin
				x = IDX_W'($urandom_range(1, plan_built));
				y = ($urandom_range(0, 19) == 0) ? x : IDX_W'($urandom_range(1, plan_built));
				push_req(pick_move(), x, y);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_box_count(11'd5);
		push_req(ACT_SWAP, 1, 2);
		push_req(ACT_INIT, 0, 0);
		push_req(ACT_REPORT, 0, 0);
		push_req(ACT_SWAP, 2, 3);
		push_req(ACT_SWAP, 2, 3);
		push_req(ACT_SWAP, 1, 5);
		push_req(ACT_REPORT, 0, 0);
		push_req(ACT_INIT, 0, 0);
		push_req(ACT_LEFT, 1, 2);
		push_req(ACT_RIGHT, 2, 1);
		push_req(ACT_LEFT, 5, 1);
		push_req(ACT_RIGHT, 1, 4);
		push_req(ACT_LEFT, 3, 3);
		push_req(ACT_RIGHT, 6, 2);
		push_req(ACT_SWAP, 0, 3);
		push_req(ACT_LEFT, 2, 1024);
		push_req(ACT_SWAP, 2047, 2047);
		push_req(ACT_SPARE_A, 1, 2);
		push_req(ACT_SPARE_B, 3, 4);
		push_req(ACT_REPORT, 2047, 2047);
		push_req(ACT_REV, 0, 0);
		push_req(ACT_REPORT, 0, 0);
		push_req(ACT_LEFT, 4, 2);
		push_req(ACT_RIGHT, 1, 3);
		push_req(ACT_SWAP, 2, 4);
		push_req(ACT_REPORT, 0, 0);
		push_req(ACT_INIT, 0, 0);
		push_req(ACT_REPORT, 0, 0);

		run_phase(11'd8, 200, 1'b1, 12, 1'b0);
		run_phase(11'd1, 60, 1'b1, 20, 1'b0);
		run_phase(11'd2, 120, 1'b1, 15, 1'b0);
		run_phase(11'd3, 150, 1'b1, 15, 1'b0);
		run_phase(11'd16, 250, 1'b1, 10, 1'b0);
		run_phase(11'd1024, 40, 1'b1, 5, 1'b0);
		// A count written after init, here zero, makes the report walk only the first box of the built line.
		run_phase(11'd0, 30, 1'b0, 30, 1'b0);
		run_phase(11'd2047, 30, 1'b1, 10, 1'b0);
		run_phase(11'd6, 150, 1'b1, 12, 1'b0);
		run_phase(11'd40, 40, 1'b0, 30, 1'b0);
		run_phase(11'd5, 300, 1'b1, 25, 1'b1);
		run_phase(11'd32, 180, 1'b1, 8, 1'b0);
		run_phase(11'd12, 200, 1'b1, 12, 1'b0);
		run_phase(11'd4, 200, 1'b1, 15, 1'b0);

		wait_idle(TAIL_CYCLES);
		$display("Run covered %0d requests under %0d box count settings, %0d sums checked.",
			reqs_taken, counts_written, sums_checked);
		if (errs == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
